### sv/ttip_pkg.sv
package ttip_pkg;

    // Field widths fixed by the interface
    localparam int UNIT_W  = 16;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int COUNT_OUT_W = 16;
    localparam int VALUE_OUT_W = 64;

    // Defaults for the top-level parameters
    localparam int VALUE_BITS_DEF = 64;
    localparam int COUNT_BITS_DEF = 16;

    // Reset radix of the base register
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [UNIT_W-1:0] CH_MINUS  = 16'h002D;
    localparam logic [UNIT_W-1:0] CH_PLUS   = 16'h002B;
    localparam logic [UNIT_W-1:0] CH_ZERO   = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_NINE   = 16'h0039;
    localparam logic [UNIT_W-1:0] CH_X_LOW  = 16'h0078;
    localparam logic [UNIT_W-1:0] CH_X_UP   = 16'h0058;
    localparam logic [UNIT_W-1:0] CH_A_UP   = 16'h0041;
    localparam logic [UNIT_W-1:0] CH_Z_UP   = 16'h005A;
    localparam logic [UNIT_W-1:0] CH_A_LOW  = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_Z_LOW  = 16'h007A;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_BODY,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // Digit status of the current string
    typedef enum logic [1:0] {
        DS_NONE,
        DS_OK,
        DS_OVF
    } status_t;

    // Classified code unit handed from front to back
    typedef struct packed {
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               digit_ok;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } class_t;

endpackage

### sv/ttip_front.sv
module ttip_front
    import ttip_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              is_last,
    output logic              push_valid,
    input  logic              push_ready,
    output class_t            push_item
);

    function automatic logic space_unit(input logic [UNIT_W-1:0] c);
        logic hit;
        hit = 1'b0;
        if (c >= 16'h0009 && c <= 16'h000D) hit = 1'b1;
        if (c >= 16'h001C && c <= 16'h0020) hit = 1'b1;
        if (c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) hit = 1'b1;
        if (c >= 16'h2000 && c <= 16'h200A) hit = 1'b1;
        if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) hit = 1'b1;
        if (c == 16'h205F || c == 16'h3000) hit = 1'b1;
        return hit;
    endfunction

    logic [UNIT_W-1:0] off_num;
    logic [UNIT_W-1:0] off_up;
    logic [UNIT_W-1:0] off_low;

    // Classify the unit
    always_comb
    begin
        off_num = code_unit - CH_ZERO;
        off_up  = code_unit - CH_A_UP + 16'd10;
        off_low = code_unit - CH_A_LOW + 16'd10;

        push_item.is_space = space_unit(code_unit);
        push_item.is_minus = (code_unit == CH_MINUS);
        push_item.is_plus  = (code_unit == CH_PLUS);
        push_item.is_zero  = (code_unit == CH_ZERO);
        push_item.is_x     = (code_unit == CH_X_LOW) || (code_unit == CH_X_UP);
        push_item.last     = is_last;
        push_item.digit_ok = 1'b1;
        push_item.digit    = '0;
        if (code_unit >= CH_ZERO && code_unit <= CH_NINE)
        begin
            push_item.digit = DIGIT_W'(off_num);
        end
        else if (code_unit >= CH_A_UP && code_unit <= CH_Z_UP)
        begin
            push_item.digit = DIGIT_W'(off_up);
        end
        else if (code_unit >= CH_A_LOW && code_unit <= CH_Z_LOW)
        begin
            push_item.digit = DIGIT_W'(off_low);
        end
        else
        begin
            push_item.digit_ok = 1'b0;
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

### sv/ttip_queue.sv
module ttip_queue
    import ttip_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  class_t push_item,
    output logic   pop_valid,
    input  logic   pop_ready,
    output class_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    class_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = q_mem[rd_ptr_reg];

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/ttip_back.sv
module ttip_back
    import ttip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  class_t            item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    localparam int PW = VALUE_BITS + BASE_W + 1;

    logic [BASE_W-1:0]     cfg_base_reg;
    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    status_t               ds_reg, ds_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [COUNT_BITS-1:0] endp_reg, endp_next;

    logic                  out_valid_reg;
    logic [VALUE_OUT_W-1:0] out_value_reg, out_value_next;
    logic [COUNT_OUT_W-1:0] out_units_reg, out_units_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_conv_reg, out_conv_next;

    logic                  fire;
    logic                  body_go;
    logic                  dig_go;
    logic [BASE_W-1:0]     eff_base;
    logic [VALUE_BITS-1:0] acc_in;
    status_t               ds_in;
    logic [BASE_W-1:0]     radix;
    logic [PW-1:0]         prod;
    logic [PW-1:0]         lim;
    logic [COUNT_BITS-1:0] pos_inc;
    status_t               fin_ds;
    logic [VALUE_BITS-1:0] fin_acc;
    logic [COUNT_BITS-1:0] fin_end;
    logic [VALUE_BITS-1:0] mag;
    logic signed [VALUE_BITS-1:0] val_s;

    // Hold only a last unit while an earlier result still waits
    assign item_ready = !item.last || !out_valid_reg || m_tready;
    assign fire       = item_valid && item_ready;
    assign pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    // Parse one unit: phase step, then one multiply-accumulate
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        endp_next  = endp_reg;
        pos_next   = pos_inc;
        body_go    = 1'b0;
        dig_go     = 1'b0;
        eff_base   = base_reg;
        acc_in     = acc_reg;
        ds_in      = ds_reg;

        case (phase_reg)
            PH_SPACE:
            begin
                if (!item.is_space)
                begin
                    base_next = cfg_base_reg;
                    eff_base  = cfg_base_reg;
                    if (item.is_minus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_BODY;
                    end
                    else if (item.is_plus)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        body_go = 1'b1;
                    end
                end
            end
            PH_BODY:
            begin
                body_go = 1'b1;
            end
            PH_PREFIX:
            begin
                phase_next = PH_DIGITS;
                if (item.is_x)
                begin
                    base_next = BASE_HEX;
                end
                else
                begin
                    // the held zero counts as a digit ending before this unit
                    base_next = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    ds_in     = DS_OK;
                    acc_in    = '0;
                    endp_next = pos_reg;
                    dig_go    = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                dig_go = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Sign done: look for a prefix zero or start the digits
        if (body_go)
        begin
            if ((eff_base == BASE_AUTO || eff_base == BASE_HEX) && item.is_zero)
            begin
                phase_next = PH_PREFIX;
            end
            else
            begin
                base_next  = (eff_base == BASE_AUTO) ? BASE_DEC : eff_base;
                phase_next = PH_DIGITS;
                dig_go     = 1'b1;
            end
        end

        acc_next = acc_in;
        ds_next  = ds_in;
        radix    = (base_next == BASE_AUTO) ? BASE_W'(1) : base_next;
        prod     = PW'(acc_in) * PW'(radix) + PW'(item.digit);
        lim      = (PW'(1) << (VALUE_BITS - 1)) - PW'(!neg_next);

        // Accumulate a digit, saturating past the limit
        if (dig_go)
        begin
            if (!item.digit_ok || item.digit >= radix)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                endp_next = pos_inc;
                if (ds_in == DS_OVF || prod > lim)
                begin
                    ds_next = DS_OVF;
                end
                else
                begin
                    ds_next  = DS_OK;
                    acc_next = prod[VALUE_BITS-1:0];
                end
            end
        end

        // Close the string: a lone held zero is the number
        fin_ds  = ds_next;
        fin_acc = acc_next;
        fin_end = endp_next;
        if (phase_next == PH_PREFIX)
        begin
            fin_ds  = DS_OK;
            fin_acc = '0;
            fin_end = pos_next;
        end

        case (fin_ds)
            DS_OVF:  mag = lim[VALUE_BITS-1:0];
            DS_OK:   mag = fin_acc;
            default: mag = '0;
        endcase
        val_s = neg_next ? -mag : mag;

        out_value_next = VALUE_OUT_W'(val_s);
        out_ovf_next   = (fin_ds == DS_OVF);
        out_conv_next  = (fin_ds != DS_NONE);
        out_units_next = out_conv_next ? COUNT_OUT_W'(fin_end) : '0;
    end

    // Hold the base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            cfg_base_reg <= cfg_data;
        end
    end

    // Update parse state; drop it after the last unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            ds_reg    <= DS_NONE;
            base_reg  <= BASE_AUTO;
            pos_reg   <= '0;
            endp_reg  <= '0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                phase_reg <= PH_SPACE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                ds_reg    <= DS_NONE;
                base_reg  <= BASE_AUTO;
                pos_reg   <= '0;
                endp_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                ds_reg    <= ds_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                endp_reg  <= endp_next;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && item.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            out_value_reg <= out_value_next;
            out_units_reg <= out_units_next;
            out_ovf_reg   <= out_ovf_next;
            out_conv_reg  <= out_conv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_units_reg, out_value_reg};
    assign m_tuser  = {out_conv_reg, out_ovf_reg};

endmodule

### sv/text_to_integer_parser_unit.sv
// Streaming strtol-style parser: one UTF-16 code unit per item on the slave
// side, s_tlast on the final unit of a string, one result per string on the
// master side. The block takes one item every cycle while the queue has
// room; the back stage updates the parse state for each unit through one
// value-by-base multiply-accumulate and limit compare. With nothing queued
// ahead of it, the last unit is written into the queue and the back stage
// then loads the output register from it, raising m_tvalid. A four-entry
// queue parts the classifying front from the parsing back, so input keeps
// flowing while a result waits; only the next last unit is held in the back
// stage until that result is taken. The base register (reset 10,
// 0 = automatic) is read when the first non-whitespace unit reaches the
// back stage; write it only while the block is idle.
module text_to_integer_parser_unit
    import ttip_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_data,     // number_base
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,      // [15:0] code_unit
    input  logic              s_tlast,      // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,      // [63:0] value, [79:64] units_consumed
    output logic [1:0]        m_tuser       // [0] overflowed, [1] converted
);

    logic   push_valid;
    logic   push_ready;
    class_t push_item;
    logic   pop_valid;
    logic   pop_ready;
    class_t pop_item;

    ttip_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .code_unit  (s_tdata),
        .is_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ttip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ttip_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### sv/ttip_checker.sv
module ttip_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    // Overflow only happens on a converted number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("overflow flagged without conversion");

    // Nothing converted gives zero value and zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata == 80'd0)
        else $error("unconverted result carries value or count");

    // A converted number consumed at least one unit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[79:64] != 16'd0)
        else $error("converted result with zero unit count");

endmodule

bind text_to_integer_parser_unit ttip_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
